// ===== src/vlc_pkg.sv =====
// shared types and constants of the vector length clamp
// no dependencies
package vlc_pkg;

  localparam int unsigned CompW     = 32;
  localparam int unsigned RootSteps = 32;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned NumLanes  = 3;

  typedef logic [CompW-1:0] comp_t;

  // side data carried beside the root pipeline
  typedef struct packed {
    logic                       vld;
    logic                       zero;
    logic [NumLanes-1:0]        neg;
    logic [NumLanes-1:0][CompW-1:0] orig;
    logic [NumLanes-1:0][CompW-1:0] mag;
  } pre_t;

  // side data carried beside the divider lanes
  typedef struct packed {
    logic                       vld;
    logic                       zero;
    logic                       clamp;
    logic [NumLanes-1:0]        neg;
    logic [NumLanes-1:0][CompW-1:0] orig;
  } post_t;

endpackage

// ===== src/vlc_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on vlc_pkg
module vlc_isqrt import vlc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [2*CompW-1:0]    rad_i,
  output logic [CompW-1:0]      root_o
);

  logic [CompW:0]       rem_q  [RootSteps+1];
  logic [CompW-1:0]     root_q [RootSteps+1];
  logic [2*CompW-1:0]   rad_q  [RootSteps+1];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = rad_i;

  for (genvar g = 0; g < RootSteps; g++) begin : g_step
    logic [CompW+2:0] trial_rem;
    logic [CompW+2:0] trial_sub;
    logic [CompW:0]   rem_d;
    logic [CompW-1:0] root_d;

    always_comb begin
      trial_rem = {rem_q[g], rad_q[g][2*CompW-1 -: 2]};
      trial_sub = {1'b0, root_q[g], 2'b01};
      if (trial_rem >= trial_sub) begin
        // remainder stays within twice the partial root, one bit above CompW
        rem_d  = (CompW+1)'(trial_rem - trial_sub);
        root_d = {root_q[g][CompW-2:0], 1'b1};
      end else begin
        rem_d  = trial_rem[CompW:0];
        root_d = {root_q[g][CompW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1]  <= rem_d;
        root_q[g+1] <= root_d;
        rad_q[g+1]  <= {rad_q[g][2*CompW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[RootSteps];

endmodule

// ===== src/vlc_div_lane.sv =====
// one divider lane: 64-bit product over 32-bit divisor, quotient below 2^32
// depends on vlc_pkg
module vlc_div_lane import vlc_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2*CompW-1:0]  prod_i,
  input  logic [CompW-1:0]    div_i,
  output logic [CompW-1:0]    quo_o
);

  logic [CompW-1:0] rem_q [DivSteps+1];
  logic [CompW-1:0] low_q [DivSteps+1];
  logic [CompW-1:0] quo_q [DivSteps+1];
  logic [CompW-1:0] div_q [DivSteps+1];

  // high half is below the divisor whenever the vector gets clamped
  assign rem_q[0] = prod_i[2*CompW-1:CompW];
  assign low_q[0] = prod_i[CompW-1:0];
  assign quo_q[0] = '0;
  assign div_q[0] = div_i;

  for (genvar g = 0; g < DivSteps; g++) begin : g_step
    logic [CompW:0]   part;
    logic [CompW-1:0] rem_d;
    logic             bit_d;

    always_comb begin
      part = {rem_q[g], low_q[g][CompW-1]};
      if (part >= {1'b0, div_q[g]}) begin
        rem_d = CompW'(part - {1'b0, div_q[g]});
        bit_d = 1'b1;
      end else begin
        rem_d = part[CompW-1:0];
        bit_d = 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1] <= rem_d;
        low_q[g+1] <= {low_q[g][CompW-2:0], 1'b0};
        quo_q[g+1] <= {quo_q[g][CompW-2:0], bit_d};
        div_q[g+1] <= div_q[g];
      end
    end
  end

  assign quo_o = quo_q[DivSteps];

endmodule

// ===== src/vector_length_clamp_unit.sv =====
// Clamps one 3D Q16.16 vector per cycle, unless the output stalls, to the length
// in max_length. Fully pipelined: a new request is taken every cycle while the
// output is not stalled; each result passes the 32-stage square root and the 32-stage
// divider lanes (one per component) plus abs, square, sum, multiply and output registers.
// The whole pipeline advances together; it holds while a result waits at the
// output register and m_axis_tready_i is low. A zero vector yields zeros with
// the zero_vector flag on m_axis_tuser_o.
module vector_length_clamp_unit import vlc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CompW-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [3*CompW-1:0]   s_axis_tdata_i,  // vec_x, vec_y, vec_z
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [3*CompW-1:0]   m_axis_tdata_o,  // out_x, out_y, out_z
  output logic                 m_axis_tuser_o   // zero_vector
);

  logic             en;
  comp_t            max_len_q;

  assign en              = m_axis_tready_i | ~m_axis_tvalid_o;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= CompW'(65536);
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // stage a: magnitudes and signs
  pre_t pre_d, pre_a_q, pre_b_q;

  always_comb begin
    pre_d      = '0;
    pre_d.vld  = s_axis_tvalid_i;
    for (int i = 0; i < NumLanes; i++) begin
      pre_d.orig[i] = s_axis_tdata_i[i*CompW +: CompW];
      pre_d.neg[i]  = pre_d.orig[i][CompW-1];
      pre_d.mag[i]  = pre_d.neg[i] ? CompW'(-pre_d.orig[i]) : pre_d.orig[i];
    end
    pre_d.zero = (s_axis_tdata_i == '0);
  end

  // stage b: squares, stage c: sum
  logic [NumLanes-1:0][2*CompW-1:0] sq_q;
  logic [2*CompW-1:0]               sum_q;
  pre_t                             pre_line_q [RootSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_a_q       <= '0;
      pre_b_q       <= '0;
      pre_line_q[0] <= '0;
      sq_q          <= '0;
      sum_q         <= '0;
    end else if (en) begin
      pre_a_q <= pre_d;
      for (int i = 0; i < NumLanes; i++) begin
        sq_q[i] <= pre_a_q.mag[i] * pre_a_q.mag[i];
      end
      pre_b_q       <= pre_a_q;
      sum_q         <= sq_q[0] + sq_q[1] + sq_q[2];
      pre_line_q[0] <= pre_b_q;
    end
  end

  comp_t root;

  vlc_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q),
    .root_o (root)
  );

  for (genvar g = 0; g < RootSteps; g++) begin : g_pre_line
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pre_line_q[g+1] <= '0;
      end else if (en) begin
        pre_line_q[g+1] <= pre_line_q[g];
      end
    end
  end

  // stage d: clamp decision and per-lane products
  pre_t                             pre_end;
  post_t                            post_line_q [DivSteps+1];
  logic [NumLanes-1:0][2*CompW-1:0] prod_q;
  comp_t                            root_q;

  assign pre_end = pre_line_q[RootSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_line_q[0] <= '0;
      root_q         <= '0;
      prod_q         <= '0;
    end else if (en) begin
      post_line_q[0].vld   <= pre_end.vld;
      post_line_q[0].zero  <= pre_end.zero;
      post_line_q[0].clamp <= root > max_len_q;
      post_line_q[0].neg   <= pre_end.neg;
      post_line_q[0].orig  <= pre_end.orig;
      root_q               <= root;
      for (int i = 0; i < NumLanes; i++) begin
        prod_q[i] <= pre_end.mag[i] * max_len_q;
      end
    end
  end

  logic [NumLanes-1:0][CompW-1:0] quo;

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    vlc_div_lane u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .prod_i (prod_q[l]),
      .div_i  (root_q),
      .quo_o  (quo[l])
    );
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_post_line
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        post_line_q[g+1] <= '0;
      end else if (en) begin
        post_line_q[g+1] <= post_line_q[g];
      end
    end
  end

  // merge: pass-through, signed quotients or zeros
  post_t                          post_end;
  logic [NumLanes-1:0][CompW-1:0] res_d;
  logic [NumLanes-1:0][CompW-1:0] res_q;
  logic                           zero_q;
  logic                           vld_q;

  assign post_end = post_line_q[DivSteps];

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      if (post_end.zero) begin
        res_d[i] = '0;
      end else if (post_end.clamp) begin
        res_d[i] = post_end.neg[i] ? CompW'(-quo[i]) : quo[i];
      end else begin
        res_d[i] = post_end.orig[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= post_end.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      zero_q <= post_end.zero;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = res_q;
  assign m_axis_tuser_o  = zero_q;

endmodule

// ===== src/vlc_checker.sv =====
// port-level checks for the vector length clamp unit, bound to the top level
// depends on vlc_pkg
module vlc_checker import vlc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tready_o,
  input  logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  input  logic [3*CompW-1:0] m_axis_tdata_o,
  input  logic               m_axis_tuser_o
);

  // a flagged zero vector carries zero components
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("zero vector result with nonzero data");

  // the pipeline must take requests whenever the output drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i || !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with free output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

endmodule

bind vector_length_clamp_unit vlc_checker u_vlc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/vector_length_clamp_unit_tb.sv =====
// testbench of the vector length clamp unit: directed and random vectors,
// predicted in place and checked against the output stream; needs vlc_pkg
`timescale 1ns / 100ps

module vector_length_clamp_unit_tb;
  import vlc_pkg::*;

  localparam int unsigned Latency  = 69;
  localparam int unsigned Watchdog = 20000;

  typedef struct packed {
    logic [CompW-1:0] x;
    logic [CompW-1:0] y;
    logic [CompW-1:0] z;
    logic             zero;
  } clamp_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CompW-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [3*CompW-1:0] s_axis_tdata_i = '0;  // vec_x, vec_y, vec_z
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [3*CompW-1:0] m_axis_tdata_o;       // out_x, out_y, out_z
  logic             m_axis_tuser_o;         // zero_vector

  logic [CompW-1:0] limit_q = 32'd65536;
  clamp_res_t       pending_q[$];
  int unsigned      n_fail = 0, n_sent = 0, n_checked = 0, idle_cycles = 0;
  int unsigned      hold_left = 0;
  bit               rx_stall_en = 1'b1;

  vector_length_clamp_unit dut (.*);

  initial forever #6 clk_i = ~clk_i;

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] rem, root, b;
    rem = n; root = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] abs_comp(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;  // -2^31 maps to 2^31 as unsigned
  endfunction

  function automatic logic [31:0] scaled_comp(logic [31:0] v, logic [63:0] m);
    logic [63:0] q;
    q = ({32'd0, abs_comp(v)} * {32'd0, limit_q}) / m;
    return v[31] ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  function automatic clamp_res_t clamped_vector(logic [31:0] x, y, z);
    clamp_res_t r;
    logic [63:0] ax, ay, az, m;
    ax = abs_comp(x); ay = abs_comp(y); az = abs_comp(z);
    r = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      r.zero = 1'b1;
      return r;
    end
    m = floor_root(ax * ax + ay * ay + az * az);
    if (m <= limit_q) begin
      r.x = x; r.y = y; r.z = z;
    end else begin
      r.x = scaled_comp(x, m); r.y = scaled_comp(y, m); r.z = scaled_comp(z, m);
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send_vector(logic [31:0] x, y, z, bit gaps = 1'b1);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_q.push_back(clamped_vector(x, y, z));
    n_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_q = v;
  endtask

  function automatic logic [31:0] rand_comp();
    int unsigned p;
    p = $urandom_range(9);
    if (p == 0) return 32'h8000_0000;
    if (p == 1) return 32'h7fff_ffff;
    if (p == 2) return 32'd0;
    if (p < 6) return $urandom_range(1 << 20) - (1 << 19);
    return $urandom();
  endfunction

  // output side: random stall, then compare against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_q.size() == 0) begin
          $error("result with no request pending");
          n_fail++;
        end else begin
          clamp_res_t e;
          e = pending_q.pop_front();
          if (m_axis_tdata_o[31:0] !== e.x) begin
            $error("out_x expected %h actual %h", e.x, m_axis_tdata_o[31:0]); n_fail++;
          end
          if (m_axis_tdata_o[63:32] !== e.y) begin
            $error("out_y expected %h actual %h", e.y, m_axis_tdata_o[63:32]); n_fail++;
          end
          if (m_axis_tdata_o[95:64] !== e.z) begin
            $error("out_z expected %h actual %h", e.z, m_axis_tdata_o[95:64]); n_fail++;
          end
          if (m_axis_tuser_o !== e.zero) begin
            $error("zero_vector expected %b actual %b", e.zero, m_axis_tuser_o); n_fail++;
          end
          n_checked++;
        end
      end
      // now and then a long stall on the output side
      if (hold_left != 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left       <= hold_left - 1;
      end else if (rx_stall_en && $urandom_range(199) == 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left       <= $urandom_range(60, 10);
      end else begin
        m_axis_tready_i <= rx_stall_en ? ($urandom_range(99) < 70) : 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Watchdog) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_vector(0, 0, 0);
    send_vector(32'h0001_0000, 0, 0);            // exactly at the default limit
    send_vector(32'h0002_0000, 0, 0);
    send_vector(0, 32'hfffe_0000, 0);
    send_vector(0, 0, 32'h8000_0000);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(32'h7fff_ffff, 32'h8000_0000, 32'd1);
    send_vector(1, 0, 0);
    send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vector(32'h0000_ffff, 32'h0000_0001, 32'h0);
    send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
  endtask

  task automatic test_random(int unsigned n);
    repeat (n) send_vector(rand_comp(), rand_comp(), rand_comp());
  endtask

  task automatic test_limits();
    write_limit(32'd1);
    test_directed();
    test_random(100);
    write_limit(32'hffff_ffff);
    test_directed();
    test_random(100);
    write_limit(32'h0000_8000);
    test_random(200);
  endtask

  task automatic test_back_to_back();
    rx_stall_en = 1'b0;
    repeat (200) send_vector(rand_comp(), rand_comp(), rand_comp(), 1'b0);
    drain();  // sender holds until every result is back
    rx_stall_en = 1'b1;
    write_limit($urandom_range(32'h0010_0000, 1));
    test_random(250);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    test_limits();
    test_back_to_back();
    drain();
    $display("sent %0d vectors over limits 1 LSB to full scale, checked %0d results",
             n_sent, n_checked);
    $display("covered zero vectors, pass-through, clamping, extreme components and stalls");
    if (n_fail == 0 && pending_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
